// ===== design/b2da_pkg.sv =====
`default_nettype none

package b2da_pkg;

   // decimal digits held for a 32-bit value
   localparam int DIGITS = 10;
   localparam int DIGIT_W = 4;
   localparam int BCD_W = DIGITS * DIGIT_W;
   localparam int POS_W = $clog2(DIGITS);

   // double-dabble steps done in each pipeline stage
   localparam int StepsPerStage = 4;

   // converted values waiting for the serializer
   localparam int BUF_DEPTH = 4;
   localparam int PTR_W = $clog2(BUF_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   localparam int FIELD_BITS = 32;
   localparam int CHAR_W = 6;
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

   localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

   typedef logic [BCD_W-1:0] bcd_type;
   typedef logic [POS_W-1:0] pos_type;

endpackage

`default_nettype wire

// ===== design/binary_to_decimal_ascii.sv =====
`default_nettype none

// Binary to decimal ASCII converter with leading zero suppression.
//
// Input: a value is taken at a rising edge where start is high and busy is
// low. Only the low VALUE_BITS bits of req_value are used.
// Output: the decimal text, most significant digit first, one beat per
// cycle on rsp_digit_char with rsp_strobe high; rsp_last marks the units
// digit. Zero gives the single beat '0'. A value gives 1 to 10 beats.
// Path: a value passes through the four-bit double-dabble stages, then the
// leading-digit stage, the result buffer and the output register, in that
// order; it waits in the result buffer while earlier values are sent.
// Throughput: the result port moves one digit per cycle; runs of buffered
// values follow each other with no gap.
// Up to four values may be in flight or buffered; busy is high while that
// credit pool is used up, so a new value can enter every cycle until then.
// Reset clears the pipeline, buffer and credits; nothing else is kept
// between values. The receiver cannot stall, so each beat is shown for one
// cycle only.
module binary_to_decimal_ascii #(
   parameter int VALUE_BITS = 32
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  wire  [b2da_pkg::FIELD_BITS-1:0]   req_value,
   output logic                              rsp_strobe,
   output logic [b2da_pkg::CHAR_W-1:0]       rsp_digit_char,
   output logic                              rsp_last
);

   localparam int EFF_BITS = (VALUE_BITS < b2da_pkg::FIELD_BITS) ?
                             VALUE_BITS : b2da_pkg::FIELD_BITS;
   localparam int NSTAGE = (EFF_BITS + b2da_pkg::StepsPerStage - 1) /
                           b2da_pkg::StepsPerStage;
   localparam int PAD_BITS = NSTAGE * b2da_pkg::StepsPerStage;
   localparam int ACC_W = b2da_pkg::BCD_W + PAD_BITS;

   function automatic logic [ACC_W-1:0] dabble(input logic [ACC_W-1:0] acc_in);
      logic [ACC_W-1:0] acc;
      int               i;
      int               d;
      acc = acc_in;
      for (i = 0; i < b2da_pkg::StepsPerStage; i++) begin
         for (d = 0; d < b2da_pkg::DIGITS; d++) begin
            if (acc[PAD_BITS + d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] >=
                b2da_pkg::DABBLE_LIMIT) begin
               acc[PAD_BITS + d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
                  acc[PAD_BITS + d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] +
                  b2da_pkg::DABBLE_ADD;
            end
         end
         acc = acc << 1;
      end
      return acc;
   endfunction

   // credits: values accepted and not yet fully sent
   logic [b2da_pkg::CNT_W-1:0] credit_ff, credit_in;
   logic                       accept;
   logic                       pop;

   assign busy = (credit_ff == b2da_pkg::CNT_W'(b2da_pkg::BUF_DEPTH));
   assign accept = start & ~busy;

   // double-dabble pipeline
   logic [ACC_W-1:0] stg_acc_ff [NSTAGE];
   logic [ACC_W-1:0] stg_acc_in [NSTAGE];
   logic [NSTAGE-1:0] stg_vld_ff;
   logic [NSTAGE-1:0] stg_vld_in;

   genvar s;
   generate
      for (s = 0; s < NSTAGE; s++) begin : g_stage
         if (s == 0) begin : g_first
            always_comb begin
               stg_acc_in[s] = dabble({{b2da_pkg::BCD_W{1'b0}},
                                       PAD_BITS'(req_value[EFF_BITS-1:0])});
               stg_vld_in[s] = accept;
            end
         end else begin : g_next
            always_comb begin
               stg_acc_in[s] = dabble(stg_acc_ff[s-1]);
               stg_vld_in[s] = stg_vld_ff[s-1];
            end
         end

         always_ff @(posedge clock) begin
            stg_acc_ff[s] <= stg_acc_in[s];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= '0;
      end else begin
         stg_vld_ff <= stg_vld_in;
      end
   end

   // leading digit stage
   b2da_pkg::bcd_type lead_bcd_in, lead_bcd_ff;
   b2da_pkg::pos_type lead_top_in, lead_top_ff;
   logic              lead_vld_ff;

   always_comb begin
      lead_bcd_in = stg_acc_ff[NSTAGE-1][ACC_W-1 -: b2da_pkg::BCD_W];
      lead_top_in = '0;
      for (int d = 0; d < b2da_pkg::DIGITS; d++) begin
         if (lead_bcd_in[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] != '0) begin
            lead_top_in = b2da_pkg::POS_W'(d);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_vld_ff <= 1'b0;
      end else begin
         lead_vld_ff <= stg_vld_ff[NSTAGE-1];
      end
      lead_bcd_ff <= lead_bcd_in;
      lead_top_ff <= lead_top_in;
   end

   // result buffer, never overfills since credits bound its fill
   b2da_pkg::bcd_type          buf_bcd_ff [b2da_pkg::BUF_DEPTH];
   b2da_pkg::pos_type          buf_top_ff [b2da_pkg::BUF_DEPTH];
   logic [b2da_pkg::PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [b2da_pkg::PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [b2da_pkg::CNT_W-1:0] buf_cnt_ff, buf_cnt_in;

   always_ff @(posedge clock) begin
      if (lead_vld_ff) begin
         buf_bcd_ff[wr_ptr_ff] <= lead_bcd_ff;
         buf_top_ff[wr_ptr_ff] <= lead_top_ff;
      end
   end

   // serializer: one digit a cycle from the buffer head
   logic              active_ff, active_in;
   b2da_pkg::pos_type pos_ff, pos_in;
   b2da_pkg::pos_type cur_pos;
   b2da_pkg::bcd_type head_bcd;
   logic [b2da_pkg::DIGIT_W-1:0] cur_digit;
   logic              head_vld;

   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic [b2da_pkg::CHAR_W-1:0] rsp_digit_char_ff, rsp_digit_char_in;
   logic                        rsp_last_ff, rsp_last_in;

   always_comb begin
      head_vld  = (buf_cnt_ff != '0);
      head_bcd  = buf_bcd_ff[rd_ptr_ff];
      cur_pos   = active_ff ? pos_ff : buf_top_ff[rd_ptr_ff];
      cur_digit = head_bcd[cur_pos*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W];
      pop       = head_vld & (cur_pos == '0);

      active_in = active_ff;
      pos_in    = pos_ff;
      if (head_vld) begin
         active_in = ~pop;
         pos_in    = cur_pos - b2da_pkg::POS_W'(1);
      end

      rsp_strobe_in     = head_vld;
      rsp_digit_char_in = b2da_pkg::ASCII_ZERO +
                          b2da_pkg::CHAR_W'(cur_digit);
      rsp_last_in       = (cur_pos == '0);

      wr_ptr_in  = wr_ptr_ff + b2da_pkg::PTR_W'(lead_vld_ff);
      rd_ptr_in  = rd_ptr_ff + b2da_pkg::PTR_W'(pop);
      buf_cnt_in = buf_cnt_ff + b2da_pkg::CNT_W'(lead_vld_ff) -
                   b2da_pkg::CNT_W'(pop);
      credit_in  = credit_ff + b2da_pkg::CNT_W'(accept) -
                   b2da_pkg::CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         buf_cnt_ff    <= '0;
         credit_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         active_ff     <= active_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         buf_cnt_ff    <= buf_cnt_in;
         credit_ff     <= credit_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      pos_ff            <= pos_in;
      rsp_digit_char_ff <= rsp_digit_char_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_digit_char = rsp_digit_char_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

// ===== verif/b2da_checker.sv =====
`timescale 1ns / 1ps

module b2da_checker #(
   parameter int VALUE_BITS = 32
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   input  wire                               busy,
   input  wire  [b2da_pkg::FIELD_BITS-1:0]   req_value,
   input  wire                               rsp_strobe,
   input  wire  [b2da_pkg::CHAR_W-1:0]       rsp_digit_char,
   input  wire                               rsp_last,
   output int                                errors,
   output int                                digits_pending
);

   // 2 << 63 wraps to zero, so a 64-bit width yields all ones
   localparam logic [63:0] VALUE_MASK = (64'd2 << (VALUE_BITS - 1)) - 64'd1;
   localparam int MAX_DIGITS = 20;

   typedef struct packed {
      logic [b2da_pkg::CHAR_W-1:0] digit_char;
      logic                        last;
   } digit_beat_type;

   digit_beat_type digits_due[$];

   // queue the decimal text of one value, most significant digit first
   function automatic void spell_decimal(input logic [b2da_pkg::FIELD_BITS-1:0] value);
      logic [63:0]    rest;
      logic [3:0]     msd_first[$];
      digit_beat_type beat;
      rest = {{(64 - b2da_pkg::FIELD_BITS){1'b0}}, value} & VALUE_MASK;
      do begin
         msd_first.push_front(4'(rest % 64'd10));
         rest = rest / 64'd10;
      end while (rest != 64'd0 && msd_first.size() < MAX_DIGITS);
      for (int k = 0; k < msd_first.size(); k++) begin
         beat.digit_char = b2da_pkg::ASCII_ZERO + {2'b00, msd_first[k]};
         beat.last = (k == msd_first.size() - 1);
         digits_due.push_back(beat);
      end
   endfunction

   always @(posedge clock) begin
      digit_beat_type want;
      int             bad;
      bad = 0;
      if (reset) begin
         digits_due.delete();
         errors <= 0;
         digits_pending <= 0;
      end else begin
         if (rsp_strobe) begin
            if (digits_due.size() == 0) begin
               $error("digit beat with nothing expected: digit_char %0d last %0d",
                      rsp_digit_char, rsp_last);
               bad++;
            end else begin
               want = digits_due.pop_front();
               if (rsp_digit_char !== want.digit_char) begin
                  $error("digit_char: expected %0d, got %0d", want.digit_char,
                         rsp_digit_char);
                  bad++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  bad++;
               end
            end
         end
         if (start && !busy)
            spell_decimal(req_value);
         errors <= errors + bad;
         digits_pending <= digits_due.size();
      end
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int RANDOM_VALUES = 500;
   localparam int MAX_GAP = 18;
   localparam int TAIL_CYCLES = 30;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic [b2da_pkg::FIELD_BITS-1:0]  req_value = '0;
   wire                              busy;
   wire                              rsp_strobe;
   wire  [b2da_pkg::CHAR_W-1:0]      rsp_digit_char;
   wire                              rsp_last;
   int                               errors;
   int                               digits_pending;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   binary_to_decimal_ascii u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   b2da_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .errors         (errors),
      .digits_pending (digits_pending)
   );

   // hold start until the value is taken, then, for a nonzero gap, drop start and wait out the gap
   task automatic send_value(input logic [31:0] value, input int gap);
      start <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         req_value <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending until every queued digit has come out
   task automatic drain_digits();
      start <= 1'b0;
      do @(posedge clock); while (digits_pending != 0);
   endtask

   function automatic longint unsigned power_of_ten(input int exponent);
      longint unsigned p;
      p = 1;
      repeat (exponent) p = p * 10;
      return p;
   endfunction

   function automatic logic [31:0] pick_value();
      int              mode;
      int              digits;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned spread;
      mode = $urandom_range(0, 9);
      if (mode <= 3)
         return $urandom;
      if (mode <= 6) begin
         // uniform over values with a chosen digit count
         digits = $urandom_range(1, 10);
         lo = (digits == 1) ? 0 : power_of_ten(digits - 1);
         hi = (digits == 10) ? 64'hFFFF_FFFF : power_of_ten(digits) - 1;
         spread = {$urandom, $urandom};
         return 32'(lo + spread % (hi - lo + 1));
      end
      if (mode == 7)
         return $urandom_range(0, 99);
      // around a power of ten, from one below it to one above it
      return 32'(power_of_ten($urandom_range(0, 9))) + 32'($urandom_range(0, 2)) - 32'd1;
   endfunction

   logic [31:0] directed_values[] = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101, 32'd999,
      32'd1000, 32'd9999999, 32'd10000000, 32'd99999999, 32'd100000000,
      32'd999999999, 32'd1000000000, 32'd1000000001, 32'd1234567890,
      32'd2147483647, 32'd2147483648, 32'd4000000000, 32'hAAAA_AAAA,
      32'h5555_5555, 32'd4294967294, 32'd4294967295
   };

   initial begin
      int burst;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_values[i])
         send_value(directed_values[i], (i % 3 == 0) ? $urandom_range(0, MAX_GAP) : 0);
      drain_digits();

      burst = 0;
      for (int n = 0; n < RANDOM_VALUES; n++) begin
         if (n % 40 == 0)
            burst = ($urandom_range(0, 2) == 0);
         send_value(pick_value(), burst ? 0 : $urandom_range(0, MAX_GAP));
         if (n % 100 == 99)
            drain_digits();
      end

      drain_digits();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (digits_pending != 0)
         $error("%0d expected digits never arrived", digits_pending);
      if (errors == 0 && digits_pending == 0) begin
         $display("PASS binary_to_decimal_ascii");
      end else begin
         $display("FAIL binary_to_decimal_ascii");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAIL binary_to_decimal_ascii");
      $finish;
   end

endmodule
